@@ hw/rtl/ekd_pkg.sv @@
`timescale 1ns / 1ps

package ekd_pkg;

    // Time base and field widths
    localparam int TIME_W      = 32;
    localparam int CODE_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int WINDOW_W    = 16;
    localparam int SAMPLE_W    = 8;

    // Footswitch bits actually debounced (1..SAMPLE_W)
    localparam int SWITCH_BITS = 8;

    // Item kinds
    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_ARM  = 1'b1;

    // Configuration register indexes
    typedef enum logic
    {
        CFG_ESC_WINDOW      = 1'b0,
        CFG_DEBOUNCE_WINDOW = 1'b1
    } cfg_index_t;

    localparam logic [WINDOW_W-1:0] ESC_WINDOW_RST      = 16'd10;
    localparam logic [WINDOW_W-1:0] DEBOUNCE_WINDOW_RST = 16'd10;

    // Characters
    localparam logic [BYTE_W-1:0] KEY_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] KEY_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] KEY_A     = 8'h41;
    localparam logic [BYTE_W-1:0] KEY_B     = 8'h42;
    localparam logic [BYTE_W-1:0] KEY_C     = 8'h43;
    localparam logic [BYTE_W-1:0] KEY_D     = 8'h44;

    // Debouncer status toward the decoder
    typedef struct packed
    {
        logic              fire;
        logic [CODE_W-1:0] value;
    } sw_status_t;

    // True for a byte that ends an escape sequence
    function automatic logic is_final(input logic [BYTE_W-1:0] b);
        logic r;
        begin
            case (b)
                KEY_TILDE, KEY_A, KEY_B, KEY_C, KEY_D: r = 1'b1;
                default:                               r = 1'b0;
            endcase
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/ekd_switch_deb.sv @@
`timescale 1ns / 1ps

module ekd_switch_deb
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              poll,
    input  logic [ekd_pkg::SAMPLE_W-1:0]      sample,
    input  logic [ekd_pkg::TIME_W-1:0]        now,
    input  logic [ekd_pkg::WINDOW_W-1:0]      window,
    output ekd_pkg::sw_status_t               status
);

    logic [ekd_pkg::SWITCH_BITS-1:0] switch_last_reg;
    logic [ekd_pkg::SWITCH_BITS-1:0] switch_stable_reg;
    logic [ekd_pkg::TIME_W-1:0]      switch_deadline_reg;

    logic [ekd_pkg::SWITCH_BITS-1:0] masked;
    logic                            changed;
    logic                            settled;

    // Compare the masked sample with the last one and check the settle time
    always_comb
    begin
        masked  = sample[ekd_pkg::SWITCH_BITS-1:0];
        changed = (masked != switch_last_reg);
        settled = !changed && (switch_deadline_reg != '0) && (now > switch_deadline_reg);
        status.fire  = settled && (switch_last_reg != switch_stable_reg);
        status.value = ekd_pkg::CODE_W'(switch_last_reg);
    end

    // Debounce state, updated only when the decoder samples the switch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_last_reg     <= '0;
            switch_stable_reg   <= '0;
            switch_deadline_reg <= '0;
        end
        else if (poll)
        begin
            if (changed)
            begin
                switch_last_reg     <= masked;
                switch_deadline_reg <= now + ekd_pkg::TIME_W'(window);
            end
            else if (settled)
            begin
                switch_deadline_reg <= '0;
                switch_stable_reg   <= switch_last_reg;
            end
        end
    end

endmodule

@@ hw/rtl/escape_key_and_switch_decoder_core.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, byte_valid, rx_byte, now, switch_sample,
//                                  repeat_delay, repeat_code
// out       out_valid / out_ready  code_valid, key_code
// cfg       cfg_we                 cfg_index, cfg_wdata
//
// Every item gives one result. It waits in the input register until the output
// register is free or drained; the decode logic between them then updates the
// state and loads the result, which raises out_valid, on one shared edge.
// One item per cycle is taken while the output is drained.
// A stalled output holds the input register, which then drops in_ready.
// Reset clears all decoder state and sets both windows to 10 ticks.

module escape_key_and_switch_decoder_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic                            byte_valid,
    input  logic [ekd_pkg::BYTE_W-1:0]      rx_byte,
    input  logic [ekd_pkg::TIME_W-1:0]      now,
    input  logic [ekd_pkg::SAMPLE_W-1:0]    switch_sample,
    input  logic [ekd_pkg::WINDOW_W-1:0]    repeat_delay,
    input  logic [ekd_pkg::CODE_W-1:0]      repeat_code,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            code_valid,
    output logic [ekd_pkg::CODE_W-1:0]      key_code,

    input  logic                            cfg_we,
    input  ekd_pkg::cfg_index_t             cfg_index,
    input  logic [ekd_pkg::WINDOW_W-1:0]    cfg_wdata
);

    // Configuration
    logic [ekd_pkg::WINDOW_W-1:0] esc_window_reg;
    logic [ekd_pkg::WINDOW_W-1:0] debounce_window_reg;

    // Input register
    logic                           s1_valid_reg;
    logic                           s1_kind_reg;
    logic                           s1_byte_valid_reg;
    logic [ekd_pkg::BYTE_W-1:0]     s1_byte_reg;
    logic [ekd_pkg::TIME_W-1:0]     s1_now_reg;
    logic [ekd_pkg::SAMPLE_W-1:0]   s1_sample_reg;
    logic [ekd_pkg::WINDOW_W-1:0]   s1_delay_reg;
    logic [ekd_pkg::CODE_W-1:0]     s1_rcode_reg;

    // Decoder state
    logic [ekd_pkg::TIME_W-1:0]     esc_deadline_reg;
    logic [ekd_pkg::TIME_W-1:0]     esc_deadline_next;
    logic [ekd_pkg::CODE_W-1:0]     esc_code_reg;
    logic [ekd_pkg::CODE_W-1:0]     esc_code_next;
    logic [ekd_pkg::TIME_W-1:0]     rpt_deadline_reg;
    logic [ekd_pkg::TIME_W-1:0]     rpt_deadline_next;
    logic [ekd_pkg::CODE_W-1:0]     rpt_code_reg;
    logic [ekd_pkg::CODE_W-1:0]     rpt_code_next;

    // Output register
    logic                           out_valid_reg;
    logic                           code_valid_reg;
    logic                           code_valid_next;
    logic [ekd_pkg::CODE_W-1:0]     key_code_reg;
    logic [ekd_pkg::CODE_W-1:0]     key_code_next;

    logic                           advance;
    logic                           sw_poll;
    logic                           esc_open;
    logic                           esc_expired;
    logic                           rpt_expired;
    logic [ekd_pkg::CODE_W-1:0]     esc_shifted;
    ekd_pkg::sw_status_t            sw_status;

    // Handshake: input stage moves when the output register is free
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign out_valid  = out_valid_reg;
    assign code_valid = code_valid_reg;
    assign key_code   = key_code_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_window_reg      <= ekd_pkg::ESC_WINDOW_RST;
            debounce_window_reg <= ekd_pkg::DEBOUNCE_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ekd_pkg::CFG_ESC_WINDOW:      esc_window_reg      <= cfg_wdata;
                ekd_pkg::CFG_DEBOUNCE_WINDOW: debounce_window_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_kind_reg       <= kind;
            s1_byte_valid_reg <= byte_valid;
            s1_byte_reg       <= rx_byte;
            s1_now_reg        <= now;
            s1_sample_reg     <= switch_sample;
            s1_delay_reg      <= repeat_delay;
            s1_rcode_reg      <= repeat_code;
        end
    end

    // Footswitch debouncer
    ekd_switch_deb u_switch_deb
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (advance && sw_poll),
        .sample (s1_sample_reg),
        .now    (s1_now_reg),
        .window (debounce_window_reg),
        .status (sw_status)
    );

    // Decode one item
    always_comb
    begin
        esc_open    = (esc_deadline_reg != '0);
        esc_expired = esc_open && (s1_now_reg > esc_deadline_reg);
        rpt_expired = (rpt_deadline_reg != '0) && (s1_now_reg > rpt_deadline_reg);
        esc_shifted = {esc_code_reg[ekd_pkg::CODE_W-ekd_pkg::BYTE_W-1:0], s1_byte_reg};

        esc_deadline_next = esc_deadline_reg;
        esc_code_next     = esc_code_reg;
        rpt_deadline_next = rpt_deadline_reg;
        rpt_code_next     = rpt_code_reg;
        code_valid_next   = 1'b0;
        key_code_next     = '0;
        sw_poll           = 1'b0;

        if (s1_kind_reg == ekd_pkg::KIND_ARM)
        begin
            rpt_deadline_next = s1_now_reg + ekd_pkg::TIME_W'(s1_delay_reg);
            rpt_code_next     = s1_rcode_reg;
        end
        else if (!s1_byte_valid_reg)
        begin
            if (esc_expired)
            begin
                esc_deadline_next = '0;
                code_valid_next   = 1'b1;
                key_code_next     = esc_code_reg;
            end
            else if (rpt_expired)
            begin
                rpt_deadline_next = '0;
                code_valid_next   = 1'b1;
                key_code_next     = rpt_code_reg;
            end
            else
            begin
                sw_poll = 1'b1;
            end
        end
        else if (esc_open)
        begin
            // Byte inside an open window, even a late one
            esc_code_next = esc_shifted;
            if (ekd_pkg::is_final(s1_byte_reg))
            begin
                esc_deadline_next = '0;
                code_valid_next   = 1'b1;
                key_code_next     = esc_shifted;
            end
            else
            begin
                sw_poll = 1'b1;
            end
        end
        else if (s1_byte_reg == ekd_pkg::KEY_ESC)
        begin
            esc_deadline_next = s1_now_reg + ekd_pkg::TIME_W'(esc_window_reg);
            esc_code_next     = ekd_pkg::CODE_W'(s1_byte_reg);
            sw_poll           = 1'b1;
        end
        else
        begin
            code_valid_next = 1'b1;
            key_code_next   = ekd_pkg::CODE_W'(s1_byte_reg);
        end

        if (sw_poll && sw_status.fire)
        begin
            code_valid_next = 1'b1;
            key_code_next   = sw_status.value;
        end
    end

    // Decoder state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_deadline_reg <= '0;
            esc_code_reg     <= '0;
            rpt_deadline_reg <= '0;
            rpt_code_reg     <= '0;
        end
        else if (advance)
        begin
            esc_deadline_reg <= esc_deadline_next;
            esc_code_reg     <= esc_code_next;
            rpt_deadline_reg <= rpt_deadline_next;
            rpt_code_reg     <= rpt_code_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_valid_reg <= code_valid_next;
            key_code_reg   <= key_code_next;
        end
    end

    // Checks
    a_no_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !code_valid_reg |-> key_code_reg == '0)
        else $error("key_code not zero without a code");

    a_arm_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_kind_reg == ekd_pkg::KIND_ARM |=> !code_valid_reg)
        else $error("arm item delivered a code");

    a_esc_open: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_kind_reg == ekd_pkg::KIND_POLL && s1_byte_valid_reg && !esc_open
            && s1_byte_reg == ekd_pkg::KEY_ESC
        |=> esc_code_reg == ekd_pkg::CODE_W'(ekd_pkg::KEY_ESC))
        else $error("escape window did not start with ESC");

endmodule
